// ===== hdl/pesq_pkg.sv =====
// shared types and constants of the pending event set queue
package pesq_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int TIME_BITS_DEF   = 48;

   localparam int MODE_W       = 2;
   localparam int COMP_W       = 8;
   localparam int EVENT_TIME_W = 48;
   localparam int TAG_W        = 16;
   localparam int STATUS_W     = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_PEEK   = 2'd1,
      MODE_TAKE   = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INSERT,
      ST_SEARCH,
      ST_PURGE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                    found;
      logic [COMP_W-1:0]       component;
      logic [EVENT_TIME_W-1:0] event_time;
      logic                    discrete;
      logic [TAG_W-1:0]        tag;
      status_type              status;
   } result_type;

endpackage

// ===== hdl/pesq_ctrl.sv =====
// slot memory with the insert, search and purge sequencer
module pesq_ctrl
   import pesq_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [MODE_W-1:0]                  req_mode,
   input  logic [COMP_W-1:0]                  req_component,
   input  logic [EVENT_TIME_W-1:0]            req_event_time,
   input  logic                               req_is_discrete,
   input  logic [TAG_W-1:0]                   req_event_tag,
   input  logic                               res_ready,
   output logic                               res_load,
   output result_type                         res_data,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]   res_occupancy
);

   localparam int AW        = $clog2(TABLE_DEPTH);
   localparam int CW        = $clog2(TABLE_DEPTH + 1);
   localparam int TAG_LSB   = 0;
   localparam int DISC_BIT  = TAG_W;
   localparam int TIME_LSB  = TAG_W + 1;
   localparam int COMP_LSB  = TIME_LSB + TIME_BITS;
   localparam int VALID_BIT = COMP_LSB + COMP_W;
   localparam int WORD_W    = VALID_BIT + 1;

   localparam logic [AW-1:0] LAST_ADDR  = AW'(TABLE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   logic [WORD_W-1:0] mem [TABLE_DEPTH];

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        iss_ff, iss_in;
   logic                 iss_end_ff, iss_end_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [AW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 rd_last_ff, rd_last_in;
   logic [WORD_W-1:0]    rd_word_ff;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [COMP_W-1:0]    comp_ff, comp_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic                 disc_ff, disc_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic                 best_found_ff, best_found_in;
   logic [AW-1:0]        best_idx_ff, best_idx_in;
   logic [WORD_W-1:0]    best_word_ff, best_word_in;
   status_type           status_ff, status_in;

   logic                 accept;
   logic                 issue;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_W-1:0]    wr_data;
   logic                 rd_slot_valid;
   logic [COMP_W-1:0]    rd_comp;
   logic [TIME_BITS-1:0] rd_time;
   logic                 rd_disc;
   logic                 better;
   logic                 purge_hit;
   logic                 is_lookup;

   assign accept        = req_valid && !req_stall;
   assign is_lookup     = (req_mode == MODE_PEEK) || (req_mode == MODE_TAKE);
   assign rd_slot_valid = rd_word_ff[VALID_BIT];
   assign rd_comp       = rd_word_ff[COMP_LSB +: COMP_W];
   assign rd_time       = rd_word_ff[TIME_LSB +: TIME_BITS];
   assign rd_disc       = rd_word_ff[DISC_BIT];
   assign better        = rd_slot_valid &&
                          (!best_found_ff || (rd_time < best_word_ff[TIME_LSB +: TIME_BITS]));
   assign purge_hit     = rd_slot_valid &&
                          ((rd_idx_ff == best_idx_ff) || ((rd_comp == comp_ff) && !rd_disc));

   // slot memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_word_ff <= mem[iss_ff];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (iss_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               priority if (req_mode == MODE_INSERT) begin
                  state_in = (count_ff == FULL_COUNT) ? ST_DONE : ST_INSERT;
               end else if (is_lookup) begin
                  state_in = (count_ff == '0) ? ST_DONE : ST_SEARCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_INSERT: begin
            if (rd_pend_ff && !rd_slot_valid) state_in = ST_DONE;
         end
         ST_SEARCH: begin
            if (rd_pend_ff && rd_last_ff) begin
               state_in = (mode_ff == MODE_TAKE) ? ST_PURGE : ST_DONE;
            end
         end
         ST_PURGE: begin
            if (rd_pend_ff && rd_last_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      issue     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = rd_idx_ff;
      wr_data   = '0;
      res_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = iss_ff;
         end
         ST_IDLE: begin
         end
         ST_INSERT: begin
            issue   = !iss_end_ff;
            wr_en   = rd_pend_ff && !rd_slot_valid;
            wr_data = {1'b1, comp_ff, time_ff, disc_ff, tag_ff};
         end
         ST_SEARCH: begin
            issue = !iss_end_ff;
         end
         ST_PURGE: begin
            issue   = !iss_end_ff;
            wr_en   = rd_pend_ff && purge_hit;
            wr_data = {1'b0, rd_word_ff[VALID_BIT-1:0]};
         end
         ST_DONE: begin
            res_load = res_ready;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      count_in      = count_ff;
      iss_in        = iss_ff;
      iss_end_in    = iss_end_ff;
      rd_pend_in    = issue;
      rd_idx_in     = iss_ff;
      rd_last_in    = (iss_ff == LAST_ADDR);
      mode_in       = mode_ff;
      comp_in       = comp_ff;
      time_in       = time_ff;
      disc_in       = disc_ff;
      tag_in        = tag_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_word_in  = best_word_ff;
      status_in     = status_ff;

      if (state_ff == ST_CLEAR) begin
         iss_in = iss_ff + 1'b1;
      end

      if (issue) begin
         iss_in     = iss_ff + 1'b1;
         iss_end_in = (iss_ff == LAST_ADDR);
      end

      if (accept) begin
         mode_in       = req_mode;
         comp_in       = req_component;
         time_in       = TIME_BITS'(req_event_time);
         disc_in       = req_is_discrete;
         tag_in        = req_event_tag;
         iss_in        = '0;
         iss_end_in    = 1'b0;
         best_found_in = 1'b0;
         priority if ((req_mode == MODE_INSERT) && (count_ff == FULL_COUNT)) begin
            status_in = STATUS_FULL;
         end else if (is_lookup && (count_ff == '0)) begin
            status_in = STATUS_EMPTY;
         end else begin
            status_in = STATUS_OK;
         end
      end

      if ((state_ff == ST_SEARCH) && rd_pend_ff) begin
         if (better) begin
            best_found_in = 1'b1;
            best_idx_in   = rd_idx_ff;
            best_word_in  = rd_word_ff;
         end
         if (rd_last_ff) begin
            iss_in     = '0;
            iss_end_in = 1'b0;
         end
      end

      if (wr_en && (state_ff == ST_INSERT)) begin
         count_in = count_ff + 1'b1;
      end
      if (wr_en && (state_ff == ST_PURGE)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         count_ff      <= '0;
         iss_ff        <= '0;
         iss_end_ff    <= 1'b0;
         rd_pend_ff    <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         iss_ff        <= iss_in;
         iss_end_ff    <= iss_end_in;
         rd_pend_ff    <= rd_pend_in;
         best_found_ff <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      rd_last_ff   <= rd_last_in;
      mode_ff      <= mode_in;
      comp_ff      <= comp_in;
      time_ff      <= time_in;
      disc_ff      <= disc_in;
      tag_ff       <= tag_in;
      best_idx_ff  <= best_idx_in;
      best_word_ff <= best_word_in;
      status_ff    <= status_in;
   end

   // fields read as zero when nothing is reported
   always_comb begin
      res_data.found      = best_found_ff;
      res_data.component  = '0;
      res_data.event_time = '0;
      res_data.discrete   = 1'b0;
      res_data.tag        = '0;
      res_data.status     = status_ff;
      if (best_found_ff) begin
         res_data.component  = best_word_ff[COMP_LSB +: COMP_W];
         res_data.event_time = EVENT_TIME_W'(best_word_ff[TIME_LSB +: TIME_BITS]);
         res_data.discrete   = best_word_ff[DISC_BIT];
         res_data.tag        = best_word_ff[TAG_LSB +: TAG_W];
      end
   end

   assign res_occupancy = count_ff;

endmodule

// ===== hdl/pending_event_set_queue.sv =====
// Pending event set queue: an unsorted table of TABLE_DEPTH event slots held in one
// synchronous memory with a single read and a single write port. Each walking operation
// scans the memory one slot per cycle through that read port: an insert walks up to the
// lowest free slot, a peek makes one pass for the earliest event, and a take makes two
// passes (one for the earliest event, one to free it and purge the non-discrete events
// of the requested component). An insert into a full table, a peek or take on an empty
// table, or an unused mode does not walk the memory at all. Ties on time go to the
// lowest slot. After reset the block sweeps the memory to mark every slot free and holds
// req_stall high meanwhile. A finished result sits in an output register, so the next
// request is taken while the previous result still waits on rsp_stall.
module pending_event_set_queue
   import pesq_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [MODE_W-1:0]                  req_mode,
   input  logic [COMP_W-1:0]                  req_component,
   input  logic [EVENT_TIME_W-1:0]            req_event_time,
   input  logic                               req_is_discrete,
   input  logic [TAG_W-1:0]                   req_event_tag,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [COMP_W-1:0]                  rsp_out_component,
   output logic [EVENT_TIME_W-1:0]            rsp_out_time,
   output logic                               rsp_out_discrete,
   output logic [TAG_W-1:0]                   rsp_out_tag,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]   rsp_occupancy,
   output logic [STATUS_W-1:0]                rsp_status
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic          res_ready;
   logic          res_load;
   result_type    res_data;
   logic [CW-1:0] res_occupancy;

   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_data_ff;
   logic [CW-1:0] rsp_occ_ff;

   pesq_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_component   (req_component),
      .req_event_time  (req_event_time),
      .req_is_discrete (req_is_discrete),
      .req_event_tag   (req_event_tag),
      .res_ready       (res_ready),
      .res_load        (res_load),
      .res_data        (res_data),
      .res_occupancy   (res_occupancy)
   );

   // output register frees up on the cycle its transfer completes
   assign res_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res_data;
         rsp_occ_ff  <= res_occupancy;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_data_ff.found;
   assign rsp_out_component = rsp_data_ff.component;
   assign rsp_out_time      = rsp_data_ff.event_time;
   assign rsp_out_discrete  = rsp_data_ff.discrete;
   assign rsp_out_tag       = rsp_data_ff.tag;
   assign rsp_occupancy     = rsp_occ_ff;
   assign rsp_status        = rsp_data_ff.status;

endmodule

// ===== verif/tb_pending_event_set_queue.sv =====
// testbench of the pending event set queue with directed and random table operations
`timescale 1ns / 1ps

module tb_pending_event_set_queue;
   import pesq_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
   localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [EVENT_TIME_W-1:0] TIME_MAX = '1;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;

   typedef struct {
      logic                    found;
      logic [COMP_W-1:0]       comp;
      logic [EVENT_TIME_W-1:0] etime;
      logic                    disc;
      logic [TAG_W-1:0]        tag;
      logic [OCC_W-1:0]        occupancy;
      status_type              status;
   } event_report_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [MODE_W-1:0]       req_mode = '0;
   logic [COMP_W-1:0]       req_component = '0;
   logic [EVENT_TIME_W-1:0] req_event_time = '0;
   logic                    req_is_discrete = 1'b0;
   logic [TAG_W-1:0]        req_event_tag = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_found;
   logic [COMP_W-1:0]       rsp_out_component;
   logic [EVENT_TIME_W-1:0] rsp_out_time;
   logic                    rsp_out_discrete;
   logic [TAG_W-1:0]        rsp_out_tag;
   logic [OCC_W-1:0]        rsp_occupancy;
   logic [STATUS_W-1:0]     rsp_status;

   bit                    pes_valid [TABLE_DEPTH];
   bit [COMP_W-1:0]       pes_comp [TABLE_DEPTH];
   bit [EVENT_TIME_W-1:0] pes_time [TABLE_DEPTH];
   bit                    pes_disc [TABLE_DEPTH];
   bit [TAG_W-1:0]        pes_tag [TABLE_DEPTH];
   int                    pes_count = 0;

   event_report_type awaited_reports [$];
   int               errors = 0;
   int               cycle_count = 0;
   bit               quiet = 1'b0;

   pending_event_set_queue u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_component     (req_component),
      .req_event_time    (req_event_time),
      .req_is_discrete   (req_is_discrete),
      .req_event_tag     (req_event_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_out_component (rsp_out_component),
      .rsp_out_time      (rsp_out_time),
      .rsp_out_discrete  (rsp_out_discrete),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_status        (rsp_status)
   );

   always #6 clock = ~clock;

   // applies one operation to the shadow table and returns the report it causes
   function automatic event_report_type apply_table_op(logic [MODE_W-1:0] mode,
         logic [COMP_W-1:0] comp, logic [EVENT_TIME_W-1:0] etime, logic disc,
         logic [TAG_W-1:0] tag);
      event_report_type r;
      int free_slot;
      int best;
      r.found = 1'b0;
      r.comp = '0;
      r.etime = '0;
      r.disc = 1'b0;
      r.tag = '0;
      r.status = STATUS_OK;
      free_slot = -1;
      best = -1;
      if (mode == MODE_INSERT) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!pes_valid[i] && free_slot < 0) begin
               free_slot = i;
            end
         end
         if (free_slot < 0) begin
            r.status = STATUS_FULL;
         end else begin
            pes_valid[free_slot] = 1'b1;
            pes_comp[free_slot] = comp;
            pes_time[free_slot] = etime;
            pes_disc[free_slot] = disc;
            pes_tag[free_slot] = tag;
            pes_count++;
         end
      end else if (mode == MODE_PEEK || mode == MODE_TAKE) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (pes_valid[i] && (best < 0 || pes_time[i] < pes_time[best])) begin
               best = i;
            end
         end
         if (best < 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.found = 1'b1;
            r.comp = pes_comp[best];
            r.etime = pes_time[best];
            r.disc = pes_disc[best];
            r.tag = pes_tag[best];
            if (mode == MODE_TAKE) begin
               pes_valid[best] = 1'b0;
               pes_count--;
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (pes_valid[i] && pes_comp[i] == comp && !pes_disc[i]) begin
                     pes_valid[i] = 1'b0;
                     pes_count--;
                  end
               end
            end
         end
      end
      r.occupancy = pes_count[OCC_W-1:0];
      return r;
   endfunction

   function automatic logic [EVENT_TIME_W-1:0] pick_time();
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return TIME_MAX;
      end else if (r < 5) begin
         return EVENT_TIME_W'($urandom_range(15));
      end
      return EVENT_TIME_W'({$urandom, $urandom});
   endfunction

   function automatic logic [COMP_W-1:0] pick_component();
      if ($urandom_range(9) < 7) begin
         return COMP_W'($urandom_range(7));
      end
      return COMP_W'($urandom_range(255));
   endfunction

   // component of a random live entry, so that takes hit real purges
   function automatic logic [COMP_W-1:0] live_component();
      int idx;
      if (pes_count == 0) begin
         return pick_component();
      end
      do begin
         idx = $urandom_range(TABLE_DEPTH - 1);
      end while (!pes_valid[idx]);
      return pes_comp[idx];
   endfunction

   task automatic push_request(logic [MODE_W-1:0] mode, logic [COMP_W-1:0] comp,
         logic [EVENT_TIME_W-1:0] etime, logic disc, logic [TAG_W-1:0] tag);
      event_report_type report;
      if (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_component <= comp;
      req_event_time <= etime;
      req_is_discrete <= disc;
      req_event_tag <= tag;
      do begin
         @(posedge clock);
      end while (req_stall);
      report = apply_table_op(mode, comp, etime, disc, tag);
      awaited_reports = {awaited_reports, report};
   endtask

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 9);
   end

   always @(posedge clock) begin : check_reports
      event_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_reports.size() == 0) begin
            $display("%0t: unexpected transfer, expected none actual tag %h status %h",
                     $time, rsp_out_tag, rsp_status);
            errors++;
         end else begin
            want = awaited_reports.pop_front();
            compare_field("found", 64'(want.found), 64'(rsp_found));
            compare_field("out_component", 64'(want.comp), 64'(rsp_out_component));
            compare_field("out_time", 64'(want.etime), 64'(rsp_out_time));
            compare_field("out_discrete", 64'(want.disc), 64'(rsp_out_discrete));
            compare_field("out_tag", 64'(want.tag), 64'(rsp_out_tag));
            compare_field("occupancy", 64'(want.occupancy), 64'(rsp_occupancy));
            compare_field("status", 64'(want.status), 64'(rsp_status));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic test_empty_table();
      push_request(MODE_PEEK, 8'd0, '0, 1'b0, '0);
      push_request(MODE_TAKE, 8'd255, TIME_MAX, 1'b1, 16'hffff);
      push_request(MODE_UNUSED, 8'd255, TIME_MAX, 1'b1, 16'hffff);
   endtask

   task automatic test_field_extremes();
      push_request(MODE_INSERT, 8'd255, TIME_MAX, 1'b1, 16'hffff);
      push_request(MODE_INSERT, 8'd0, '0, 1'b0, 16'h0000);
      push_request(MODE_PEEK, 8'd0, '0, 1'b0, '0);
      push_request(MODE_TAKE, 8'd0, '0, 1'b0, '0);
      push_request(MODE_PEEK, 8'd0, '0, 1'b0, '0);
      push_request(MODE_UNUSED, 8'd0, '0, 1'b0, '0);
      push_request(MODE_TAKE, 8'd255, TIME_MAX, 1'b1, 16'hffff);
   endtask

   // equal times resolve to the lowest slot; purge follows the request component
   task automatic test_ties_and_purge();
      push_request(MODE_INSERT, 8'd5, 48'd100, 1'b0, 16'h0001);
      push_request(MODE_INSERT, 8'd5, 48'd100, 1'b1, 16'h0002);
      push_request(MODE_INSERT, 8'd9, 48'd100, 1'b0, 16'h0003);
      push_request(MODE_INSERT, 8'd5, 48'd300, 1'b0, 16'h0004);
      push_request(MODE_INSERT, 8'd5, 48'd400, 1'b1, 16'h0005);
      push_request(MODE_PEEK, 8'd0, '0, 1'b0, '0);
      push_request(MODE_TAKE, 8'd9, '0, 1'b0, '0);
      push_request(MODE_PEEK, 8'd0, '0, 1'b0, '0);
      push_request(MODE_TAKE, 8'd5, '0, 1'b0, '0);
      push_request(MODE_INSERT, 8'd7, 48'd400, 1'b0, 16'h0006);
      push_request(MODE_PEEK, 8'd0, '0, 1'b0, '0);
      push_request(MODE_TAKE, 8'd5, '0, 1'b0, '0);
      push_request(MODE_TAKE, 8'd7, '0, 1'b0, '0);
   endtask

   task automatic test_fill_to_full();
      while (pes_count < TABLE_DEPTH) begin
         push_request(MODE_INSERT, pick_component(), pick_time(), 1'($urandom_range(1)),
                      16'($urandom_range(65535)));
      end
      repeat (3) begin
         push_request(MODE_INSERT, pick_component(), pick_time(), 1'($urandom_range(1)),
                      16'($urandom_range(65535)));
      end
      push_request(MODE_PEEK, pick_component(), pick_time(), 1'b0, '0);
      push_request(MODE_TAKE, live_component(), pick_time(), 1'b1, '1);
   endtask

   task automatic test_random_mix();
      int n;
      int r;
      bit filling;
      logic [MODE_W-1:0] mode;
      logic [COMP_W-1:0] comp;
      n = 0;
      filling = 1'b1;
      while (n < 1500) begin
         quiet = (n >= 600 && n < 900);
         if (pes_count == TABLE_DEPTH && $urandom_range(3) == 0) begin
            filling = 1'b0;
         end else if (pes_count < 4 && $urandom_range(2) == 0) begin
            filling = 1'b1;
         end
         r = $urandom_range(99);
         if (r < 3) begin
            mode = MODE_UNUSED;
         end else if (r < (filling ? 83 : 23)) begin
            mode = MODE_INSERT;
         end else if (r < (filling ? 91 : 38)) begin
            mode = MODE_PEEK;
         end else begin
            mode = MODE_TAKE;
         end
         comp = (mode == MODE_TAKE && $urandom_range(1)) ? live_component() : pick_component();
         push_request(mode, comp, pick_time(), 1'($urandom_range(1)),
                      16'($urandom_range(65535)));
         if (mode != MODE_UNUSED) begin
            n++;
         end
      end
      quiet = 1'b0;
   endtask

   task automatic test_drain();
      while (pes_count > 0) begin
         push_request(MODE_TAKE, live_component(), pick_time(), 1'($urandom_range(1)),
                      16'($urandom_range(65535)));
      end
      push_request(MODE_PEEK, pick_component(), pick_time(), 1'b1, '1);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_field_extremes();
      test_ties_and_purge();
      test_fill_to_full();
      test_random_mix();
      test_drain();
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
